// ===== src/multi_queue_shared_store_assert.svh =====
// assertion macros for the shared-store queue block
`ifndef MULTI_QUEUE_SHARED_STORE_ASSERT_SVH
`define MULTI_QUEUE_SHARED_STORE_ASSERT_SVH

// same-cycle implication
`define MQSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MQSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mqss_pkg.sv =====
package mqss_pkg;

   localparam int QSEL_W   = 3;
   localparam int DATA_IO_W = 32;

   typedef enum logic {
      KIND_ENQUEUE = 1'b0,
      KIND_DEQUEUE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                      kind;
      logic [QSEL_W-1:0]             queue_select;
      logic signed [DATA_IO_W-1:0]   data_in;
   } req_word_type;

   typedef struct packed {
      status_type                    status;
      logic signed [DATA_IO_W-1:0]   data_out;
   } rsp_word_type;

endpackage

// ===== src/mqss_ram.sv =====
module mqss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-first: a read of the address being written sees the new word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/multi_queue_shared_store.sv =====
// QUEUE_COUNT fifo queues sharing one store of ENTRY_COUNT entries.
// req channel (valid/ready): a word carries kind (enqueue or dequeue),
// queue_select and data_in. rsp channel (valid/ready): one word per request,
// status (done, full, empty) and data_out (dequeued value, else zero).
// a request passes an input register, a stage in which the link and value
// memories are read (registered read port), and lands in an output register
// from which its result is offered. one request is taken every cycle while
// the rsp side does not stall; the next request's read address is formed
// from the state being written back by the one ahead of it.
// when the rsp side stalls, the pipeline holds and req_ready drops once the
// input register is occupied; the output register lets a new request in
// while a finished result is still waiting.
// reset (synchronous) empties all queues and puts every entry on the free
// list at once: no clearing pass, as links of never-used entries are
// supplied by a fill count rather than read from memory.
module multi_queue_shared_store #(
   parameter int QUEUE_COUNT = 8,
   parameter int ENTRY_COUNT = 256,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mqss_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mqss_pkg::rsp_word_type  rsp_word
);

   import mqss_pkg::*;

`include "multi_queue_shared_store_assert.svh"

   localparam int PTR_W  = $clog2(ENTRY_COUNT + 1);
   localparam int ADDR_W = $clog2(ENTRY_COUNT);
   localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRY_COUNT);

   // pipeline registers
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         s2_valid_ff, s2_valid_in;
   req_word_type s2_word_ff;
   logic         s2_fresh_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // queue and free-list state
   logic [PTR_W-1:0] head_ff [QUEUE_COUNT];
   logic [PTR_W-1:0] head_in [QUEUE_COUNT];
   logic [PTR_W-1:0] tail_ff [QUEUE_COUNT];
   logic [PTR_W-1:0] tail_in [QUEUE_COUNT];
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [PTR_W-1:0] fill_ff, fill_in;

   logic s1_adv;
   logic s2_fire;

   logic              s1_q_ok;
   logic [QIDX_W-1:0] s1_qi;
   logic [PTR_W-1:0]  s1_ptr;
   logic [ADDR_W-1:0] rd_addr;
   logic              s1_fresh;

   logic              s2_q_ok;
   logic [QIDX_W-1:0] s2_qi;
   logic [PTR_W-1:0]  s2_head;
   logic [PTR_W-1:0]  s2_tail;
   logic [PTR_W-1:0]  s2_ptr;
   logic [PTR_W-1:0]  s2_link;
   logic              s2_enq_ok;
   logic              s2_deq_ok;

   logic                  link_wr_en;
   logic [ADDR_W-1:0]     link_wr_addr;
   logic [PTR_W-1:0]      link_wr_data;
   logic [PTR_W-1:0]      link_rd_data;
   logic                  value_wr_en;
   logic [ADDR_W-1:0]     value_wr_addr;
   logic [DATA_WIDTH-1:0] value_wr_data;
   logic [DATA_WIDTH-1:0] value_rd_data;

   // handshake
   assign s2_fire   = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_fire);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_adv);
      s2_valid_in  = s1_adv || (s2_valid_ff && !s2_fire);
      rsp_valid_in = s2_fire || (rsp_valid_ff && !rsp_ready);
   end

   // read address from the state as left by the word ahead
   always_comb begin
      s1_q_ok = 32'(s1_word_ff.queue_select) < 32'(QUEUE_COUNT);
      s1_qi   = s1_q_ok ? QIDX_W'(s1_word_ff.queue_select) : '0;
      if (s1_word_ff.kind == KIND_ENQUEUE) begin
         s1_ptr = free_head_in;
      end else begin
         s1_ptr = head_in[s1_qi];
      end
      rd_addr  = ADDR_W'(s1_ptr);
      // entries at or above the fill count were never used: their link is the next index
      s1_fresh = s1_ptr >= fill_in;
   end

   always_comb begin
      s2_q_ok   = 32'(s2_word_ff.queue_select) < 32'(QUEUE_COUNT);
      s2_qi     = s2_q_ok ? QIDX_W'(s2_word_ff.queue_select) : '0;
      s2_head   = head_ff[s2_qi];
      s2_tail   = tail_ff[s2_qi];
      s2_enq_ok = (s2_word_ff.kind == KIND_ENQUEUE) && s2_q_ok && (free_head_ff < NIL);
      s2_deq_ok = (s2_word_ff.kind == KIND_DEQUEUE) && s2_q_ok && (s2_head < NIL);
      if (s2_word_ff.kind == KIND_ENQUEUE) begin
         s2_ptr = free_head_ff;
      end else begin
         s2_ptr = s2_head;
      end
      s2_link = s2_fresh_ff ? s2_ptr + PTR_W'(1) : link_rd_data;
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      link_wr_en    = 1'b0;
      link_wr_addr  = ADDR_W'(s2_tail);
      link_wr_data  = free_head_ff;
      value_wr_en   = 1'b0;
      value_wr_addr = ADDR_W'(free_head_ff);
      value_wr_data = DATA_WIDTH'($unsigned(s2_word_ff.data_in));
      rsp_word_in.status   = STATUS_DONE;
      rsp_word_in.data_out = '0;

      if (s2_word_ff.kind == KIND_ENQUEUE) begin
         if (!s2_enq_ok) begin
            rsp_word_in.status = STATUS_FULL;
         end else if (s2_fire) begin
            free_head_in = s2_link;
            if (s2_head >= NIL) begin
               head_in[s2_qi] = free_head_ff;
            end else if (s2_tail < NIL) begin
               link_wr_en = 1'b1;
            end
            tail_in[s2_qi] = free_head_ff;
            value_wr_en    = 1'b1;
            if (free_head_ff >= fill_ff) begin
               fill_in = free_head_ff + PTR_W'(1);
            end
         end
      end else begin
         if (!s2_deq_ok) begin
            rsp_word_in.status = STATUS_EMPTY;
         end else begin
            rsp_word_in.data_out = 32'(value_rd_data);
            if (s2_fire) begin
               // the tail's own link is never written, so a lone entry ends the queue
               head_in[s2_qi] = (s2_head == s2_tail) ? NIL : s2_link;
               link_wr_en     = 1'b1;
               link_wr_addr   = ADDR_W'(s2_head);
               free_head_in   = s2_head;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         fill_ff      <= '0;
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            head_ff[q] <= NIL;
            tail_ff[q] <= NIL;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_word_ff <= req_word;
      end
      if (s1_adv) begin
         s2_word_ff  <= s1_word_ff;
         s2_fresh_ff <= s1_fresh;
      end
      if (s2_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   mqss_ram #(
      .WIDTH (PTR_W),
      .DEPTH (ENTRY_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (s1_adv),
      .rd_addr (rd_addr),
      .rd_data (link_rd_data)
   );

   mqss_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (ENTRY_COUNT)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_wr_en),
      .wr_addr (value_wr_addr),
      .wr_data (value_wr_data),
      .rd_en   (s1_adv),
      .rd_addr (rd_addr),
      .rd_data (value_rd_data)
   );

   `MQSS_ASSERT_NEXT(a_deq_frees_entry, clock, reset, s2_fire && s2_deq_ok, free_head_ff == $past(s2_head), "dequeued entry not at the free-list head")
   `MQSS_ASSERT_NEXT(a_enq_sets_tail, clock, reset, s2_fire && s2_enq_ok, tail_ff[$past(s2_qi)] == $past(free_head_ff), "enqueued entry not at the queue tail")
   `MQSS_ASSERT_NOW(a_fresh_in_order, clock, reset, s2_fire && s2_enq_ok && (free_head_ff >= fill_ff), free_head_ff == fill_ff, "unused entry taken out of order")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mqss_pkg::*;

   localparam int QUEUES       = 8;
   localparam int ENTRIES      = 256;
   localparam int LINK_W       = $clog2(ENTRIES + 1);
   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 16;

   localparam int PH_NONE = 0;
   localparam int PH_SEND = 1;
   localparam int PH_RECV = 2;
   localparam int PH_BOTH = 3;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

   typedef struct {
      req_word_type word;
      int           phase;
   } pending_word_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   pending_word_type pending_words[$];
   rsp_word_type     expected_rsp[$];

   // predicted store state
   logic [31:0]       entry_value[ENTRIES];
   logic [LINK_W-1:0] next_link[ENTRIES];
   logic [LINK_W-1:0] q_head[QUEUES];
   logic [LINK_W-1:0] q_tail[QUEUES];
   logic [LINK_W-1:0] free_head;

   // shadow lengths used only to steer the stimulus
   int unsigned gen_len[QUEUES];
   int unsigned gen_used;

   int   cur_phase = PH_NONE;
   bit   req_took;
   int   quiet_cycles;
   int   error_count;
   int   enq_done, enq_full, deq_done, deq_empty;

   multi_queue_shared_store #(
      .QUEUE_COUNT(QUEUES),
      .ENTRY_COUNT(ENTRIES),
      .DATA_WIDTH (32)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   function automatic void clear_store_model();
      for (int i = 0; i < ENTRIES; i++) begin
         entry_value[i] = '0;
         next_link[i]   = (i + 1 < ENTRIES) ? LINK_W'(i + 1) : NULL_LINK;
      end
      for (int i = 0; i < QUEUES; i++) begin
         q_head[i] = NULL_LINK;
         q_tail[i] = NULL_LINK;
      end
      free_head = '0;
   endfunction

   function automatic rsp_word_type apply_store_op(req_word_type w);
      rsp_word_type      r;
      int unsigned       q;
      logic [LINK_W-1:0] slot;
      r.status   = STATUS_DONE;
      r.data_out = '0;
      q = w.queue_select;
      if (w.kind == KIND_ENQUEUE) begin
         slot = free_head;
         if (q >= QUEUES || slot >= ENTRIES) begin
            r.status = STATUS_FULL;
            enq_full++;
         end else begin
            free_head = next_link[slot];
            if (free_head >= ENTRIES) free_head = NULL_LINK;
            // an empty queue restarts from its head, the stale tail is not touched
            if (q_head[q] >= ENTRIES) q_head[q] = slot;
            else if (q_tail[q] < ENTRIES) next_link[q_tail[q]] = slot;
            next_link[slot]   = NULL_LINK;
            q_tail[q]         = slot;
            entry_value[slot] = w.data_in;
            enq_done++;
         end
      end else begin
         if (q >= QUEUES || q_head[q] >= ENTRIES) begin
            r.status = STATUS_EMPTY;
            deq_empty++;
         end else begin
            slot       = q_head[q];
            q_head[q]  = (next_link[slot] < ENTRIES) ? next_link[slot] : NULL_LINK;
            next_link[slot] = free_head;
            free_head  = slot;
            r.data_out = entry_value[slot];
            deq_done++;
         end
      end
      return r;
   endfunction

   function automatic void add_item(kind_type k, int unsigned q, logic [31:0] d, int ph);
      pending_word_type p;
      p.word.kind         = k;
      p.word.queue_select = QSEL_W'(q);
      p.word.data_in      = d;
      p.phase             = ph;
      pending_words.push_back(p);
      if (k == KIND_ENQUEUE && gen_used < ENTRIES) begin
         gen_len[q]++;
         gen_used++;
      end else if (k == KIND_DEQUEUE && gen_len[q] > 0) begin
         gen_len[q]--;
         gen_used--;
      end
   endfunction

   function automatic logic [31:0] pick_data();
      logic [31:0] corners[4] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
      if ($urandom_range(99) < 15) return corners[$urandom_range(3)];
      return $urandom;
   endfunction

   function automatic bit stall_now(int ph, bit rx);
      int unsigned pct;
      pct = 0;
      if (ph == PH_BOTH) pct = 19;
      else if ((ph == PH_SEND && !rx) || (ph == PH_RECV && rx)) pct = 60;
      return $urandom_range(99) < pct;
   endfunction

   task automatic report_mismatch(string what, rsp_word_type got, rsp_word_type want);
      $display("[%0t] mismatch: %s: got status %0d data %h, wanted status %0d data %h",
               $realtime, what, got.status, got.data_out, want.status, want.data_out);
      error_count++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_words.size() > 0 && !stall_now(pending_words[0].phase, 1'b0)) begin
            req_valid <= 1'b1;
            req_word  <= pending_words[0].word;
            cur_phase <= pending_words[0].phase;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && !stall_now(cur_phase, 1'b1);
   end

   // acceptance, prediction, checking and watchdog
   always @(posedge clock) begin
      rsp_word_type want;
      req_took = req_valid && req_ready;
      if (!reset) begin
         if (req_took) begin
            expected_rsp.push_back(apply_store_op(req_word));
            void'(pending_words.pop_front());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response word with nothing outstanding", rsp_word, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_word.status !== want.status)
                  report_mismatch("status", rsp_word, want);
               if (rsp_word.data_out !== want.data_out)
                  report_mismatch("data_out", rsp_word, want);
            end
         end
         if (req_took || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      bit          filling;
      bit          enq;
      int unsigned q;
      int unsigned hot_q;
      int          ph;

      clear_store_model();
      gen_used = 0;
      foreach (gen_len[i]) gen_len[i] = 0;

      // empty queues straight out of reset
      add_item(KIND_DEQUEUE, 0, 32'h1234_5678, PH_NONE);
      add_item(KIND_DEQUEUE, 7, 32'hffff_ffff, PH_NONE);
      // extremes of data, lowest and highest queue
      add_item(KIND_ENQUEUE, 0, 32'h7fff_ffff, PH_NONE);
      add_item(KIND_ENQUEUE, 0, 32'h8000_0000, PH_NONE);
      add_item(KIND_ENQUEUE, 7, 32'hffff_ffff, PH_NONE);
      add_item(KIND_ENQUEUE, 3, 32'h0000_0000, PH_NONE);
      add_item(KIND_DEQUEUE, 0, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 0, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 0, 32'h0, PH_NONE);
      // queue 0 now has a stale tail; its old entries get reused elsewhere first
      add_item(KIND_ENQUEUE, 5, 32'h5555_5555, PH_NONE);
      add_item(KIND_ENQUEUE, 0, 32'haaaa_aaaa, PH_NONE);
      add_item(KIND_ENQUEUE, 5, 32'h0f0f_0f0f, PH_NONE);
      add_item(KIND_DEQUEUE, 5, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 0, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 0, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 7, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 3, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 3, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 5, 32'h0, PH_NONE);
      add_item(KIND_ENQUEUE, 4, 32'h0000_0001, PH_NONE);
      add_item(KIND_ENQUEUE, 4, 32'hffff_fffe, PH_NONE);
      add_item(KIND_DEQUEUE, 4, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 4, 32'h0, PH_NONE);
      add_item(KIND_DEQUEUE, 6, 32'h0, PH_NONE);

      // random part: fill the shared store until it refuses, then drain, repeat
      filling = 1'b1;
      hot_q   = $urandom_range(QUEUES - 1);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         ph = i * 4 / RANDOM_ITEMS;
         if (filling && gen_used == ENTRIES) begin
            repeat (3) add_item(KIND_ENQUEUE, $urandom_range(QUEUES - 1), pick_data(), ph);
            filling = 1'b0;
         end
         enq = filling ? ($urandom_range(99) < 90) : ($urandom_range(99) < 10);
         if (enq) begin
            q = ($urandom_range(99) < 30) ? hot_q : $urandom_range(QUEUES - 1);
            add_item(KIND_ENQUEUE, q, pick_data(), ph);
         end else begin
            q = $urandom_range(QUEUES - 1);
            if (gen_used > 0 && $urandom_range(99) < 85)
               while (gen_len[q] == 0) q = (q + 1) % QUEUES;
            add_item(KIND_DEQUEUE, q, $urandom, ph);
         end
         if (!filling && gen_used < 16) begin
            filling = 1'b1;
            hot_q   = $urandom_range(QUEUES - 1);
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d requests: %0d enqueues stored, %0d refused as full,",
               enq_done + enq_full + deq_done + deq_empty, enq_done, enq_full);
      $display("  %0d dequeues returned a word, %0d refused as empty; %0d mismatches",
               deq_done, deq_empty, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
